/* design/nmcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nmcf_pkg;

  // Geometry defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Label and stream widths.
  localparam int CLASS_W = 2;
  localparam int TDATA_W = 8;
  localparam int PAD_W   = TDATA_W - CLASS_W;

  // Configuration register widths and port shape.
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int MN_W       = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_NEIGHBORS = 2'd2;

  // Register values after reset.
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH   = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [MN_W-1:0] RST_MIN_NEIGHBORS = 4'd5;

  // Input item kinds carried on tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // The label that spreads.
  localparam logic [CLASS_W-1:0] CLASS_SHALLOW = 2'd2;

  // Frame-edge flags of the pixel being filtered, plus the frame-end mark.
  typedef struct packed {
    logic no_top;
    logic no_bot;
    logic no_left;
    logic no_right;
    logic last;
  } nmcf_edge_t;

endpackage

`default_nettype wire

/* design/nmcf_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Both line stores in one memory: each entry holds {upper, lower} for a column.
// A read that collides with a write at the same edge gets the written data.
module nmcf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q_r;
  logic [DW-1:0] fwd_q_r;
  logic          fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r  <= mem[rd_addr];
      fwd_q_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_q_r : rd_q_r;

endmodule

`default_nettype wire

/* design/nmcf_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// Holds the left and center columns of the 3x3 neighborhood; the right column
// is the one arriving this cycle. Counts class-2 neighbors inside the frame.
module nmcf_window (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            clear,
  input  wire logic                            shift,
  input  wire nmcf_pkg::nmcf_edge_t            edges,
  input  wire logic [nmcf_pkg::CLASS_W-1:0]    new_up,
  input  wire logic [nmcf_pkg::CLASS_W-1:0]    new_mid,
  input  wire logic [nmcf_pkg::CLASS_W-1:0]    new_low,
  input  wire logic [nmcf_pkg::MN_W-1:0]       min_neighbors,
  output logic      [nmcf_pkg::CLASS_W-1:0]    result
);

  import nmcf_pkg::*;

  // Index 0 is the row above the center, 2 the row below.
  logic [CLASS_W-1:0] lcol_r [3];
  logic [CLASS_W-1:0] ccol_r [3];
  logic [CLASS_W-1:0] rcol   [3];
  logic [MN_W-1:0]    cnt;

  assign rcol[0] = new_up;
  assign rcol[1] = new_mid;
  assign rcol[2] = new_low;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < 3; i++) begin
        lcol_r[i] <= '0;
        ccol_r[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 3; i++) begin
        lcol_r[i] <= ccol_r[i];
        ccol_r[i] <= rcol[i];
      end
    end
  end

  always_comb begin
    logic row_ok [3];
    row_ok[0] = !edges.no_top;
    row_ok[1] = 1'b1;
    row_ok[2] = !edges.no_bot;
    cnt = '0;
    for (int i = 0; i < 3; i++) begin
      cnt = cnt + MN_W'(row_ok[i] && !edges.no_left && (lcol_r[i] == CLASS_SHALLOW));
      cnt = cnt + MN_W'(row_ok[i] && !edges.no_right && (rcol[i] == CLASS_SHALLOW));
    end
    cnt = cnt + MN_W'(row_ok[0] && (ccol_r[0] == CLASS_SHALLOW));
    cnt = cnt + MN_W'(row_ok[2] && (ccol_r[2] == CLASS_SHALLOW));
  end

  always_comb begin
    if (ccol_r[1] == CLASS_SHALLOW || cnt >= min_neighbors) begin
      result = CLASS_SHALLOW;
    end else begin
      result = ccol_r[1];
    end
  end

endmodule

`default_nettype wire

/* design/neighbor_majority_class_fill.sv */
`timescale 1ns / 1ps
`default_nettype none

// 3x3 threshold dilation of a streamed label image, one pass per frame.
//
// Input channel (in_*): one transaction per pixel in raster order. in_tuser
// marks a flush transaction, which carries no pixel and only drains results
// once the frame's last pixel is in; before that a flush is accepted and
// ignored. Result channel (out_*): one filtered label per transaction, with
// out_tlast on the frame's final pixel. Configuration (cfg_*): single-cycle
// register writes; a write to a defined register aborts any frame in progress
// and clears position and window, while the line stores keep their contents.
//
// The result for pixel p is produced by input transaction p + width + 1
// (flush transactions feed the tail); out_tvalid rises when that transaction
// leaves the second stage. Unstalled, one transaction per cycle is sustained:
// each pixel costs one read and one write of the line-store memory, spread
// over the two pipeline stages, with a bypass for back-to-back accesses to
// one column. When the receiver stalls, the result waits in the output
// register; the stage behind it still takes one transaction that has a
// result, then in_tready drops until the output drains. Reset restores the
// register defaults and empties the pipeline; line-store contents are not
// cleared, since every entry is written before it reaches a result.
module neighbor_majority_class_fill #(
  parameter int MAX_WIDTH  = nmcf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nmcf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Pixel input; tdata: pixel_class [1:0], zero padding above.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [nmcf_pkg::TDATA_W-1:0]      in_tdata,
  // tuser: cmd [0] (0 pixel, 1 flush).
  input  wire logic                              in_tuser,
  // Result output; tdata: out_class [1:0], zero padding above.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [nmcf_pkg::TDATA_W-1:0]      out_tdata,
  output logic                                   out_tlast,
  // Configuration writes.
  input  wire logic                              cfg_we,
  input  wire logic [nmcf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [nmcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import nmcf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int LW = 2 * CLASS_W;

  typedef logic [CW-1:0] col_t;
  typedef logic [CW:0]   wcnt_t;
  typedef logic [RW-1:0] row_t;

  // Configuration registers.
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [MN_W-1:0] min_neighbors_r;
  logic            cfg_clear;

  // Frame position counters.
  col_t in_col_r,  in_col_nxt;
  row_t in_row_r,  in_row_nxt;
  col_t out_col_r, out_col_nxt;
  row_t out_row_r, out_row_nxt;

  wcnt_t eff_w;
  row_t  eff_h;

  logic               in_fire;
  logic               row_in_frame;
  logic               item_live;
  logic               due;
  logic               col_wrap;
  logic [CLASS_W-1:0] pix0;
  nmcf_edge_t         edge0;

  // Second stage: line-store data arrives, window shifts, result forms.
  logic               s1_valid_r;
  logic               s1_have_r;
  logic [CLASS_W-1:0] s1_pix_r;
  col_t               s1_addr_r;
  nmcf_edge_t         s1_edge_r;
  logic               s1_go;

  logic [LW-1:0]      ls_rd;
  logic [LW-1:0]      ls_wr;
  logic [CLASS_W-1:0] filt;

  // Output register.
  logic               out_valid_r;
  logic [CLASS_W-1:0] out_class_r;
  logic               out_last_r;

  // Clamp the frame size to what the counters and memory support; zero counts as one.
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = wcnt_t'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = wcnt_t'(MAX_WIDTH);
    end else begin
      eff_w = wcnt_t'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = row_t'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = row_t'(MAX_HEIGHT);
    end else begin
      eff_h = row_t'(frame_height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      min_neighbors_r <= RST_MIN_NEIGHBORS;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[FH_W-1:0];
        CFG_MIN_NEIGHBORS: min_neighbors_r <= cfg_wdata[MN_W-1:0];
        default: ;
      endcase
    end
  end

  // Only writes to existing registers restart the frame.
  always_comb begin
    case (cfg_addr)
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_MIN_NEIGHBORS: cfg_clear = cfg_we;
      default:                                              cfg_clear = 1'b0;
    endcase
  end

  // First stage: classify the transaction and issue the line-store read.
  assign in_fire      = in_tvalid && in_tready;
  assign row_in_frame = in_row_r < eff_h;
  // A flush inside the frame is swallowed; past the frame every item drains.
  assign item_live    = in_fire && !(row_in_frame && in_tuser == CMD_FLUSH);
  assign pix0         = row_in_frame ? in_tdata[CLASS_W-1:0] : '0;
  assign due          = (in_row_r > row_t'(1)) || (in_row_r == row_t'(1) && in_col_r != '0);
  assign col_wrap     = (wcnt_t'(in_col_r) + wcnt_t'(1)) >= eff_w;

  always_comb begin
    edge0.no_top   = out_row_r == '0;
    edge0.no_bot   = (out_row_r + row_t'(1)) >= eff_h;
    edge0.no_left  = out_col_r == '0;
    edge0.no_right = (wcnt_t'(out_col_r) + wcnt_t'(1)) >= eff_w;
    edge0.last     = (out_row_r == eff_h - row_t'(1))
                  && (wcnt_t'(out_col_r) == eff_w - wcnt_t'(1));
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_clear || (item_live && due && edge0.last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (item_live) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + row_t'(1);
      end else begin
        in_col_nxt = in_col_r + col_t'(1);
      end
      if (due) begin
        if (edge0.no_right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + row_t'(1);
        end else begin
          out_col_nxt = out_col_r + col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // An item that yields no result never waits on the output register.
  assign s1_go     = s1_valid_r && (!s1_have_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (item_live) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_live) begin
      s1_have_r <= due;
      s1_pix_r  <= pix0;
      s1_addr_r <= in_col_r;
      s1_edge_r <= edge0;
    end
  end

  // Entry layout {upper, lower}: the lower row moves up, the new pixel
  // becomes the lower row.
  assign ls_wr = {ls_rd[CLASS_W-1:0], s1_pix_r};

  nmcf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (LW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (item_live),
    .rd_addr (in_col_r),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data (ls_wr),
    .rd_data (ls_rd)
  );

  nmcf_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear         (cfg_clear || (s1_go && s1_have_r && s1_edge_r.last)),
    .shift         (s1_go),
    .edges         (s1_edge_r),
    .new_up        (ls_rd[LW-1:CLASS_W]),
    .new_mid       (ls_rd[CLASS_W-1:0]),
    .new_low       (s1_pix_r),
    .min_neighbors (min_neighbors_r),
    .result        (filt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_have_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_have_r) begin
      out_class_r <= filt;
      out_last_r  <= s1_edge_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_class_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* design/nmcf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nmcf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [nmcf_pkg::TDATA_W-1:0]    out_tdata,
  input wire logic                            out_tlast
);

  import nmcf_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A new result rises only after an accepted input transaction has passed the second stage.
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching input transaction");

  // The padding above the label stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:CLASS_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind neighbor_majority_class_fill nmcf_checker u_nmcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
